// ===== rtl/aws_pkg.sv =====
// aws_pkg: shared types and codes for the arming watchdog supervisor
// holds the one-hot state type, event, mode and reason codes and register indexes
// no dependencies
package aws_pkg;

    // configuration register width and reset timeout
    localparam int unsigned CFG_W = 32;
    localparam logic [CFG_W-1:0] TIMEOUT_RST = 32'd100;

    // register indexes
    localparam logic REG_CMD_TIMEOUT = 1'b0;
    localparam logic REG_FB_TIMEOUT  = 1'b1;

    // event kinds
    localparam logic [2:0] FN_HELLO    = 3'd0;
    localparam logic [2:0] FN_COMMAND  = 3'd1;
    localparam logic [2:0] FN_FEEDBACK = 3'd2;
    localparam logic [2:0] FN_MODE     = 3'd3;
    localparam logic [2:0] FN_EVALUATE = 3'd4;
    localparam logic [2:0] FN_INT_ERR  = 3'd5;

    // requested modes
    localparam logic [1:0] MODE_DISARM = 2'd0;
    localparam logic [1:0] MODE_ARM    = 2'd1;

    // reported state codes
    localparam logic [2:0] SC_WAIT_LINK = 3'd0;
    localparam logic [2:0] SC_DISARMED  = 3'd1;
    localparam logic [2:0] SC_SAFE      = 3'd2;
    localparam logic [2:0] SC_ACTIVE    = 3'd3;
    localparam logic [2:0] SC_FAULT     = 3'd4;

    // reason codes
    localparam logic [2:0] RSN_NONE       = 3'd0;
    localparam logic [2:0] RSN_MANUAL     = 3'd1;
    localparam logic [2:0] RSN_PROTOCOL   = 3'd2;
    localparam logic [2:0] RSN_CMD_STALE  = 3'd3;
    localparam logic [2:0] RSN_FB_STALE   = 3'd4;
    localparam logic [2:0] RSN_INT_ERROR  = 3'd5;

    // supervisor state, one-hot
    typedef enum logic [4:0] {
        ST_WAIT_LINK = 5'b00001,
        ST_DISARMED  = 5'b00010,
        ST_SAFE      = 5'b00100,
        ST_ACTIVE    = 5'b01000,
        ST_FAULT     = 5'b10000
    } t_state;

    // map the one-hot state onto its reported code
    function automatic logic [2:0] state_code(input t_state st);
        logic [2:0] code;
        case (st)
            ST_WAIT_LINK: code = SC_WAIT_LINK;
            ST_DISARMED:  code = SC_DISARMED;
            ST_SAFE:      code = SC_SAFE;
            ST_ACTIVE:    code = SC_ACTIVE;
            ST_FAULT:     code = SC_FAULT;
            default:      code = SC_WAIT_LINK;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/arming_watchdog_supervisor_core.sv =====
// arming_watchdog_supervisor_core: top level of the arming watchdog supervisor
// depends on aws_pkg for state type and codes
//
// Usage:
// Events arrive on the input channel (i_in_valid / o_in_stall) with a kind,
// a requested mode and a wrapping millisecond timestamp. Each event gives one
// result beat on the output channel (o_out_valid / i_out_stall) with the
// supervisor state, the reason, whether a mode request was accepted and
// whether link and both streams are fresh at the event's timestamp.
// An accepted event is held in an input register; once the output register
// is free the state update and the age checks (one subtract and compare per
// stream) run and the result lands in the output register. One event per
// cycle is taken while the receiver does not stall.
// When the receiver stalls, the output register holds its beat and the input
// register still takes one more event; o_in_stall rises only while both
// registers are full and the output is stalled.
// The two timeout registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data, which the user does only while no event is in flight; the
// block has no check for it. Reset (i_rst_n low, synchronous) empties both
// registers, sets the state to wait link with no reason, drops link and
// stream flags, and loads both timeouts with 100 ms.
module arming_watchdog_supervisor_core
    import aws_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // event channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_func,
    input  logic [1:0]            i_requested_mode,
    input  logic [TIME_WIDTH-1:0] i_now_time,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_safety_state,
    output logic [2:0]            o_safety_reason,
    output logic                  o_request_accepted,
    output logic                  o_streams_fresh
);

    // compare width covers both ages and timeouts
    localparam int unsigned CW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    logic [CFG_W-1:0]      r_cmd_timeout;
    logic [CFG_W-1:0]      r_fb_timeout;

    logic                  r_in_valid;
    logic [2:0]            r_func;
    logic [1:0]            r_mode;
    logic [TIME_WIDTH-1:0] r_now;

    t_state                r_state, n_state;
    logic [2:0]            r_reason, n_reason;
    logic                  r_link_up, n_link_up;
    logic                  r_cmd_seen, n_cmd_seen;
    logic                  r_fb_seen, n_fb_seen;
    logic [TIME_WIDTH-1:0] r_last_cmd, n_last_cmd;
    logic [TIME_WIDTH-1:0] r_last_fb, n_last_fb;

    logic                  r_out_valid;
    logic [2:0]            r_out_state;
    logic [2:0]            r_out_reason;
    logic                  r_out_accepted;
    logic                  r_out_fresh;

    logic                  out_free;
    logic                  advance;
    logic                  in_take;
    logic [TIME_WIDTH-1:0] cmd_age;
    logic [TIME_WIDTH-1:0] fb_age;
    logic                  cmd_ok;
    logic                  fb_ok;
    logic                  n_accepted;

    // handshake control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_timeout <= TIMEOUT_RST;
            r_fb_timeout  <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CMD_TIMEOUT: r_cmd_timeout <= i_cfg_data;
                REG_FB_TIMEOUT:  r_fb_timeout  <= i_cfg_data;
                default:         r_cmd_timeout <= r_cmd_timeout;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func <= i_func;
            r_mode <= i_requested_mode;
            r_now  <= i_now_time;
        end
    end

    // stream bookkeeping, taken from the event kind alone
    always_comb begin
        n_link_up  = r_link_up;
        n_cmd_seen = r_cmd_seen;
        n_fb_seen  = r_fb_seen;
        n_last_cmd = r_last_cmd;
        n_last_fb  = r_last_fb;
        case (r_func)
            FN_HELLO: begin
                n_link_up  = 1'b1;
                n_cmd_seen = 1'b0;
                n_fb_seen  = 1'b0;
                n_last_cmd = '0;
                n_last_fb  = '0;
            end
            FN_COMMAND: begin
                n_cmd_seen = 1'b1;
                n_last_cmd = r_now;
            end
            FN_FEEDBACK: begin
                n_fb_seen = 1'b1;
                n_last_fb = r_now;
            end
            default: begin
                n_link_up = r_link_up;
            end
        endcase
    end

    // stream ages by modular subtraction against the updated times
    assign cmd_age = r_now - n_last_cmd;
    assign fb_age  = r_now - n_last_fb;
    assign cmd_ok  = n_cmd_seen && (CW'(cmd_age) <= CW'(r_cmd_timeout));
    assign fb_ok   = n_fb_seen && (CW'(fb_age) <= CW'(r_fb_timeout));

    // state and reason update
    always_comb begin
        n_state    = r_state;
        n_reason   = r_reason;
        n_accepted = 1'b0;
        case (r_func)
            FN_HELLO: begin
                n_state  = ST_DISARMED;
                n_reason = RSN_NONE;
            end
            FN_MODE: begin
                if (r_mode == MODE_DISARM) begin
                    n_state    = ST_DISARMED;
                    n_reason   = RSN_MANUAL;
                    n_accepted = 1'b1;
                end else if (r_mode != MODE_ARM || !r_link_up) begin
                    n_state  = ST_SAFE;
                    n_reason = RSN_PROTOCOL;
                end else if (!cmd_ok) begin
                    n_state  = ST_SAFE;
                    n_reason = RSN_CMD_STALE;
                end else if (!fb_ok) begin
                    n_state  = ST_SAFE;
                    n_reason = RSN_FB_STALE;
                end else begin
                    n_state    = ST_ACTIVE;
                    n_reason   = RSN_NONE;
                    n_accepted = 1'b1;
                end
            end
            FN_EVALUATE: begin
                if (r_state == ST_ACTIVE) begin
                    if (!cmd_ok) begin
                        n_state  = ST_SAFE;
                        n_reason = RSN_CMD_STALE;
                    end else if (!fb_ok) begin
                        n_state  = ST_SAFE;
                        n_reason = RSN_FB_STALE;
                    end
                end
            end
            FN_INT_ERR: begin
                n_state  = ST_FAULT;
                n_reason = RSN_INT_ERROR;
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    // supervisor state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_WAIT_LINK;
            r_reason   <= RSN_NONE;
            r_link_up  <= 1'b0;
            r_cmd_seen <= 1'b0;
            r_fb_seen  <= 1'b0;
            r_last_cmd <= '0;
            r_last_fb  <= '0;
        end else if (advance) begin
            r_state    <= n_state;
            r_reason   <= n_reason;
            r_link_up  <= n_link_up;
            r_cmd_seen <= n_cmd_seen;
            r_fb_seen  <= n_fb_seen;
            r_last_cmd <= n_last_cmd;
            r_last_fb  <= n_last_fb;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_state    <= state_code(n_state);
            r_out_reason   <= n_reason;
            r_out_accepted <= n_accepted;
            r_out_fresh    <= n_link_up && cmd_ok && fb_ok;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_safety_state     = r_out_state;
    assign o_safety_reason    = r_out_reason;
    assign o_request_accepted = r_out_accepted;
    assign o_streams_fresh    = r_out_fresh;

    // an accepted request leaves the block disarmed or active
    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_request_accepted |->
            (o_safety_state == SC_DISARMED || o_safety_state == SC_ACTIVE))
        else $error("accepted request with unexpected state");

    // fault is only ever reported with the internal error reason
    a_fault_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_safety_state == SC_FAULT |-> o_safety_reason == RSN_INT_ERROR)
        else $error("fault without internal error reason");

    // fresh streams need a link that has come up
    a_fresh_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_streams_fresh |-> r_link_up)
        else $error("streams fresh without link");

    // input stalls only with both registers full and the output stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

endmodule

// ===== sim/tb_arming_watchdog_supervisor_core.sv =====
`timescale 1ns / 100ps
// tb_arming_watchdog_supervisor_core: self-checking bench for the arming watchdog supervisor
// queue-fed event driver, stalling result monitor and an in-bench model of the arming rules
// depends on aws_pkg and arming_watchdog_supervisor_core
module tb_arming_watchdog_supervisor_core;
    import aws_pkg::*;

    localparam int unsigned TW            = 32;
    localparam int unsigned HANG_LIMIT    = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS   = 10;

    // codes the package leaves unnamed
    localparam logic [2:0] FN_SPARE_6 = 3'd6;
    localparam logic [2:0] FN_SPARE_7 = 3'd7;
    localparam logic [1:0] MODE_BAD_2 = 2'd2;
    localparam logic [1:0] MODE_BAD_3 = 2'd3;

    typedef struct packed {
        logic [2:0]    func;
        logic [1:0]    mode;
        logic [TW-1:0] now;
    } t_event;

    typedef struct packed {
        logic [2:0] state;
        logic [2:0] reason;
        logic       accepted;
        logic       fresh;
    } t_verdict;

    // clock, reset and block ports
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = REG_CMD_TIMEOUT;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [2:0]       ev_func   = FN_HELLO;
    logic [1:0]       ev_mode   = MODE_DISARM;
    logic [TW-1:0]    ev_now    = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [2:0]       res_state;
    logic [2:0]       res_reason;
    logic             res_accepted;
    logic             res_fresh;

    // supervisor model state
    logic [2:0]       sup_state  = SC_WAIT_LINK;
    logic [2:0]       sup_reason = RSN_NONE;
    logic             link_ok    = 1'b0;
    logic             cmd_seen   = 1'b0;
    logic             fb_seen    = 1'b0;
    logic [TW-1:0]    cmd_stamp  = '0;
    logic [TW-1:0]    fb_stamp   = '0;
    logic [CFG_W-1:0] cmd_limit  = TIMEOUT_RST;
    logic [CFG_W-1:0] fb_limit   = TIMEOUT_RST;

    t_event      pending_events[$];
    t_verdict    expected_verdicts[$];
    int unsigned failures     = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned idle_odds    = 8;
    logic        calm         = 1'b0;
    int unsigned quiet_cycles = 0;
    logic [TW-1:0] wall_clock = '0;

    arming_watchdog_supervisor_core #(
        .TIME_WIDTH(TW)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_func             (ev_func),
        .i_requested_mode   (ev_mode),
        .i_now_time         (ev_now),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_safety_state     (res_state),
        .o_safety_reason    (res_reason),
        .o_request_accepted (res_accepted),
        .o_streams_fresh    (res_fresh)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // stream freshness, ages taken modulo 2^TW
    function automatic logic cmd_fresh(input logic [TW-1:0] t);
        logic [TW-1:0] age;
        age = t - cmd_stamp;
        return cmd_seen && (age <= cmd_limit);
    endfunction

    function automatic logic fb_fresh(input logic [TW-1:0] t);
        logic [TW-1:0] age;
        age = t - fb_stamp;
        return fb_seen && (age <= fb_limit);
    endfunction

    // apply one event to the model and return the beat it should produce
    function automatic t_verdict supervise(input t_event ev);
        t_verdict v;
        v = '0;
        case (ev.func)
            FN_HELLO: begin
                link_ok    = 1'b1;
                cmd_seen   = 1'b0;
                fb_seen    = 1'b0;
                cmd_stamp  = '0;
                fb_stamp   = '0;
                sup_state  = SC_DISARMED;
                sup_reason = RSN_NONE;
            end
            FN_COMMAND: begin
                cmd_seen  = 1'b1;
                cmd_stamp = ev.now;
            end
            FN_FEEDBACK: begin
                fb_seen  = 1'b1;
                fb_stamp = ev.now;
            end
            FN_MODE: begin
                if (ev.mode == MODE_DISARM) begin
                    sup_state  = SC_DISARMED;
                    sup_reason = RSN_MANUAL;
                    v.accepted = 1'b1;
                end else if (ev.mode != MODE_ARM || !link_ok) begin
                    sup_state  = SC_SAFE;
                    sup_reason = RSN_PROTOCOL;
                end else if (!cmd_fresh(ev.now)) begin
                    sup_state  = SC_SAFE;
                    sup_reason = RSN_CMD_STALE;
                end else if (!fb_fresh(ev.now)) begin
                    sup_state  = SC_SAFE;
                    sup_reason = RSN_FB_STALE;
                end else begin
                    sup_state  = SC_ACTIVE;
                    sup_reason = RSN_NONE;
                    v.accepted = 1'b1;
                end
            end
            FN_EVALUATE: begin
                if (sup_state == SC_ACTIVE) begin
                    if (!cmd_fresh(ev.now)) begin
                        sup_state  = SC_SAFE;
                        sup_reason = RSN_CMD_STALE;
                    end else if (!fb_fresh(ev.now)) begin
                        sup_state  = SC_SAFE;
                        sup_reason = RSN_FB_STALE;
                    end
                end
            end
            FN_INT_ERR: begin
                sup_state  = SC_FAULT;
                sup_reason = RSN_INT_ERROR;
            end
            default: begin
            end
        endcase
        v.state  = sup_state;
        v.reason = sup_reason;
        v.fresh  = link_ok && cmd_fresh(ev.now) && fb_fresh(ev.now);
        return v;
    endfunction

    // event driver: predicts on each accepted beat, then offers the next one
    always @(posedge clk) begin : drive_events
        t_event nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_verdicts.push_back(supervise('{ev_func, ev_mode, ev_now}));
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left = calm ? 0 : gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_events.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (!calm && idle_odds != 0 &&
                             $urandom_range(idle_odds - 1, 0) == 0) begin
                    gap_left = $urandom_range(15, 0);
                    in_valid <= 1'b0;
                end else begin
                    nxt = pending_events.pop_front();
                    in_valid <= 1'b1;
                    ev_func  <= nxt.func;
                    ev_mode  <= nxt.mode;
                    ev_now   <= nxt.now;
                end
            end
        end
    end

    // result monitor: compares each beat with the oldest prediction, stalls in bursts
    always @(posedge clk) begin : check_results
        t_verdict got;
        t_verdict want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                got = '{res_state, res_reason, res_accepted, res_fresh};
                if (expected_verdicts.size() == 0) begin
                    if (failures < MAX_REPORTS)
                        $display({"unexpected result beat: ",
                                  "state %0d reason %0d acc %0b fresh %0b"},
                                 got.state, got.reason, got.accepted, got.fresh);
                    failures++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got !== want) begin
                        if (failures < MAX_REPORTS)
                            $display({"mismatch: expected state %0d reason %0d acc %0b ",
                                      "fresh %0b, got state %0d reason %0d acc %0b fresh %0b"},
                                     want.state, want.reason, want.accepted, want.fresh,
                                     got.state, got.reason, got.accepted, got.fresh);
                        failures++;
                    end
                end
            end
            if (stall_left != 0 && !calm) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!calm && idle_odds != 0 &&
                         $urandom_range(idle_odds - 1, 0) == 0) begin
                stall_left = $urandom_range(15, 0);
                out_stall <= 1'b1;
            end else begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
        end
    end

    // hang guard: too long without any beat on either side
    always @(posedge clk) begin : hang_guard
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("arming_watchdog_supervisor_core verification failed");
            $finish;
        end
    end

    task automatic queue_event(input logic [2:0] f, input logic [1:0] m,
                               input logic [TW-1:0] t);
        pending_events.push_back('{f, m, t});
    endtask

    // wait until every event is through and every beat has come back
    task automatic drain();
        do @(negedge clk);
        while (pending_events.size() != 0 || in_valid || expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write both timeouts while the block is idle
    task automatic set_timeouts(input logic [CFG_W-1:0] cmd_to, input logic [CFG_W-1:0] fb_to);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CMD_TIMEOUT;
        cfg_data  <= cmd_to;
        @(posedge clk);
        cfg_index <= REG_FB_TIMEOUT;
        cfg_data  <= fb_to;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cmd_limit = cmd_to;
        fb_limit  = fb_to;
        @(negedge clk);
    endtask

    // time step that mostly keeps streams fresh and often lands on the timeout edge
    function automatic logic [TW-1:0] time_step(input logic [CFG_W-1:0] lim);
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 65)
            return $urandom_range((lim >> 2) + 1, 0);
        else if (pick < 90)
            return lim + $urandom_range(2, 0) - 1;
        else
            return $urandom();
    endfunction

    // one link session: hello, then mostly stream traffic with arm and evaluate
    task automatic run_session(input int unsigned len);
        int unsigned roll;
        logic [1:0]  junk_mode;
        wall_clock = wall_clock + time_step(cmd_limit);
        queue_event(FN_HELLO, 2'($urandom_range(3, 0)), wall_clock);
        repeat (len) begin
            wall_clock = wall_clock + time_step($urandom_range(1, 0) ? cmd_limit : fb_limit);
            roll       = $urandom_range(99, 0);
            junk_mode  = 2'($urandom_range(3, 0));
            if (roll < 28)
                queue_event(FN_COMMAND, junk_mode, wall_clock);
            else if (roll < 56)
                queue_event(FN_FEEDBACK, junk_mode, wall_clock);
            else if (roll < 72)
                queue_event(FN_MODE, MODE_ARM, wall_clock);
            else if (roll < 86)
                queue_event(FN_EVALUATE, junk_mode, wall_clock);
            else if (roll < 89)
                queue_event(FN_MODE, MODE_DISARM, wall_clock);
            else if (roll < 92)
                queue_event(FN_MODE, $urandom_range(1, 0) ? MODE_BAD_2 : MODE_BAD_3, wall_clock);
            else if (roll < 94)
                queue_event(FN_INT_ERR, junk_mode, wall_clock);
            else if (roll < 96)
                queue_event(FN_HELLO, junk_mode, wall_clock);
            else
                // noise beat: any kind, any mode, any time
                queue_event(3'($urandom_range(7, 0)), junk_mode, $urandom());
        end
    endtask

    task automatic random_phase(input logic [CFG_W-1:0] cmd_to, input logic [CFG_W-1:0] fb_to,
                                input int unsigned odds, input int unsigned items);
        int unsigned made;
        int unsigned len;
        set_timeouts(cmd_to, fb_to);
        idle_odds = odds;
        made      = 0;
        while (made < items) begin
            len = $urandom_range(30, 8);
            run_session(len);
            made += len + 1;
        end
        drain();
    endtask

    // stimulus sequence
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: no link, boundaries, every kind and mode, wrap of the timestamp
        queue_event(FN_EVALUATE, MODE_DISARM, 32'd0);
        queue_event(FN_MODE,     MODE_ARM,    32'd5);
        queue_event(FN_MODE,     MODE_DISARM, 32'd6);
        queue_event(FN_SPARE_6,  MODE_ARM,    32'd6);
        queue_event(FN_HELLO,    MODE_BAD_3,  32'd10);
        queue_event(FN_MODE,     MODE_ARM,    32'd10);
        queue_event(FN_COMMAND,  MODE_DISARM, 32'd20);
        queue_event(FN_MODE,     MODE_ARM,    32'd20);
        queue_event(FN_FEEDBACK, MODE_DISARM, 32'd30);
        queue_event(FN_MODE,     MODE_BAD_2,  32'd30);
        queue_event(FN_MODE,     MODE_BAD_3,  32'd30);
        queue_event(FN_MODE,     MODE_ARM,    32'd120);
        queue_event(FN_EVALUATE, MODE_DISARM, 32'd121);
        queue_event(FN_COMMAND,  MODE_DISARM, 32'd200);
        queue_event(FN_MODE,     MODE_ARM,    32'd200);
        queue_event(FN_FEEDBACK, MODE_DISARM, 32'd200);
        queue_event(FN_MODE,     MODE_ARM,    32'd200);
        queue_event(FN_EVALUATE, MODE_DISARM, 32'd300);
        queue_event(FN_MODE,     MODE_DISARM, 32'd300);
        queue_event(FN_INT_ERR,  MODE_DISARM, 32'd301);
        queue_event(FN_SPARE_7,  MODE_ARM,    32'd301);
        queue_event(FN_HELLO,    MODE_DISARM, 32'hFFFF_FFF0);
        queue_event(FN_COMMAND,  MODE_DISARM, 32'hFFFF_FFF0);
        queue_event(FN_FEEDBACK, MODE_DISARM, 32'hFFFF_FFFF);
        queue_event(FN_MODE,     MODE_ARM,    32'h0000_0010);
        drain();

        // random sessions over a spread of timeouts and idling densities
        random_phase(32'd0,          32'd0,          4,  75);
        random_phase(32'hFFFF_FFFF,  32'hFFFF_FFFF,  8,  75);
        random_phase(32'd0,          32'hFFFF_FFFF,  0,  75);
        random_phase(32'hFFFF_FFFF,  32'd0,          3,  75);
        random_phase($urandom_range(500, 1), $urandom_range(500, 1), 16, 75);
        random_phase($urandom(),     $urandom(),     6,  75);

        // last stretch with no idling on either side
        calm = 1'b1;
        random_phase(TIMEOUT_RST, TIMEOUT_RST, 0, 75);

        failures += expected_verdicts.size();
        if (failures == 0)
            $display("arming_watchdog_supervisor_core verification clean");
        else
            $display("arming_watchdog_supervisor_core verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/aws_pkg.sv
rtl/arming_watchdog_supervisor_core.sv
sim/tb_arming_watchdog_supervisor_core.sv
